/* rtl/sfsr_pkg.sv */
package sfsr_pkg;

   localparam int MAX_SUBFILES = 16;
   localparam int SIZE_BITS    = 48;

   localparam int INDEX_BITS  = 5;
   localparam int MODE_BITS   = 2;
   localparam int UNIT_BITS   = 25;
   localparam int FACTOR_BITS = 5;
   localparam int PREFIX_BITS = 32;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   // register indexes, taken from paddr[3:2]
   localparam logic [1:0] REG_LAYOUT_MODE = 2'd0;
   localparam logic [1:0] REG_STRIP_UNIT  = 2'd1;
   localparam logic [1:0] REG_FACTOR      = 2'd2;
   localparam logic [1:0] REG_PREFIX      = 2'd3;

   localparam logic [MODE_BITS-1:0]   MODE_RESET   = '0;
   localparam logic [UNIT_BITS-1:0]   UNIT_RESET   = UNIT_BITS'(65536);
   localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = FACTOR_BITS'(1);
   localparam logic [PREFIX_BITS-1:0] PREFIX_RESET = '0;

   localparam int DIV_STEPS  = SIZE_BITS;
   localparam int MUL_STEPS  = UNIT_BITS;
   localparam int COUNT_BITS = $clog2(DIV_STEPS > MUL_STEPS ? DIV_STEPS : MUL_STEPS);

   typedef struct packed {
      logic [INDEX_BITS-1:0] subfile_index;
      logic [SIZE_BITS-1:0]  stored_length;
      logic [SIZE_BITS-1:0]  current_size;
      logic                  last_item;
   } req_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] rebuilt_size;
      logic                 size_grew;
   } rsp_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]   layout_mode;
      logic [UNIT_BITS-1:0]   strip_unit_bytes;
      logic [FACTOR_BITS-1:0] stripe_factor;
      logic [PREFIX_BITS-1:0] hybrid_prefix_bytes;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mulf;
      logic strips;
      logic mul_step;
      logic clamp;
      logic update;
   } dp_cmd_type;

   typedef struct packed {
      logic strip_path;
      logic last;
      logic rsp_busy;
   } dp_sts_type;

endpackage

/* rtl/sfsr_csr.sv */
module sfsr_csr
   import sfsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_index;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_LAYOUT_MODE: cfg_in.layout_mode         = csr_pwdata[MODE_BITS-1:0];
            REG_STRIP_UNIT:  cfg_in.strip_unit_bytes    = csr_pwdata[UNIT_BITS-1:0];
            REG_FACTOR:      cfg_in.stripe_factor       = csr_pwdata[FACTOR_BITS-1:0];
            REG_PREFIX:      cfg_in.hybrid_prefix_bytes = csr_pwdata[PREFIX_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_LAYOUT_MODE: csr_prdata = CSR_DATA_BITS'(cfg_ff.layout_mode);
         REG_STRIP_UNIT:  csr_prdata = CSR_DATA_BITS'(cfg_ff.strip_unit_bytes);
         REG_FACTOR:      csr_prdata = CSR_DATA_BITS'(cfg_ff.stripe_factor);
         REG_PREFIX:      csr_prdata = CSR_DATA_BITS'(cfg_ff.hybrid_prefix_bytes);
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_mode         <= MODE_RESET;
         cfg_ff.strip_unit_bytes    <= UNIT_RESET;
         cfg_ff.stripe_factor       <= FACTOR_RESET;
         cfg_ff.hybrid_prefix_bytes <= PREFIX_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/sfsr_ctrl.sv */
module sfsr_ctrl
   import sfsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  dp_sts_type sts,
   output dp_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV    = 3'd1;
   localparam logic [2:0] ST_MULF   = 3'd2;
   localparam logic [2:0] ST_STRIPS = 3'd3;
   localparam logic [2:0] ST_MUL    = 3'd4;
   localparam logic [2:0] ST_CLAMP  = 3'd5;
   localparam logic [2:0] ST_UPDATE = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // master strip, skipped index or empty subfile: nothing to divide
            if (!sts.strip_path) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.div_step = 1'b1;
               if (count_ff == COUNT_BITS'(DIV_STEPS - 1)) begin
                  count_in = '0;
                  state_in = ST_MULF;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end
         end
         ST_MULF: begin
            cmd.mulf = 1'b1;
            state_in = ST_STRIPS;
         end
         ST_STRIPS: begin
            cmd.strips = 1'b1;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (count_ff == COUNT_BITS'(MUL_STEPS - 1)) begin
               count_in = '0;
               state_in = ST_CLAMP;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold the final request until the output register is free
            if (!(sts.last && sts.rsp_busy)) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_DIV))
      else $error("accepted request did not start the divider pass");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (count_ff < COUNT_BITS'(MUL_STEPS)))
      else $error("multiply step counter out of range");
`endif

endmodule

/* rtl/sfsr_dp.sv */
module sfsr_dp
   import sfsr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cfg_type    cfg,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int QF_BITS  = SIZE_BITS + FACTOR_BITS;
   localparam int STR_BITS = QF_BITS + 1;
   localparam int MC_BITS  = SIZE_BITS + UNIT_BITS;
   localparam int ACC_BITS = MC_BITS + 1;
   localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = '1;

   logic [SIZE_BITS-1:0]   len_ff, len_in;     // dividend, then quotient
   logic [UNIT_BITS-1:0]   rem_ff, rem_in;
   logic [INDEX_BITS-1:0]  idx_ff;
   logic [SIZE_BITS-1:0]   cur_ff;
   logic                   last_ff;
   logic                   strip_ff;
   logic [SIZE_BITS-1:0]   ext_ff, ext_in;
   logic [QF_BITS-1:0]     qf_ff;
   logic [MC_BITS-1:0]     mcand_ff, mcand_in;
   logic [UNIT_BITS-1:0]   ushift_ff, ushift_in;
   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [SIZE_BITS-1:0]   max_ff, max_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic [UNIT_BITS-1:0]   unit_eff;
   logic [FACTOR_BITS-1:0] factor_eff;
   logic [PREFIX_BITS-1:0] prefix_eff;
   logic                   striped, hybrid;
   logic                   master_ok, strip_ok;
   logic [UNIT_BITS:0]     r_sh, r_sub;
   logic                   ge;
   logic                   rem_zero;
   logic [SIZE_BITS-1:0]   q_adj;
   logic [INDEX_BITS-1:0]  idx_add;
   logic [STR_BITS-1:0]    strips_sum;
   logic [SIZE_BITS-1:0]   strips_sat;
   logic [SIZE_BITS-1:0]   new_max;

   assign striped    = (cfg.layout_mode != '0);
   assign hybrid     = cfg.layout_mode[1];
   assign unit_eff   = (cfg.strip_unit_bytes == '0) ? UNIT_BITS'(1) : cfg.strip_unit_bytes;
   assign factor_eff = (cfg.stripe_factor > FACTOR_BITS'(MAX_SUBFILES)) ?
                       FACTOR_BITS'(MAX_SUBFILES) : cfg.stripe_factor;
   assign prefix_eff = hybrid ? cfg.hybrid_prefix_bytes : '0;

   assign master_ok = (req_data.subfile_index == '0) && (!striped || hybrid);
   assign strip_ok  = (req_data.subfile_index != '0) && striped &&
                      (req_data.subfile_index <= factor_eff) &&
                      (req_data.stored_length != '0);

   // restoring divider, one quotient bit a cycle
   assign r_sh  = {rem_ff, len_ff[SIZE_BITS-1]};
   assign ge    = (r_sh >= {1'b0, unit_eff});
   assign r_sub = r_sh - {1'b0, unit_eff};

   // exact multiple of the unit: last byte sits at the end of the previous strip
   assign rem_zero = (rem_ff == '0);
   assign q_adj    = rem_zero ? (len_ff - SIZE_BITS'(1)) : len_ff;
   assign idx_add  = rem_zero ? idx_ff : (idx_ff - INDEX_BITS'(1));

   assign strips_sum = {1'b0, qf_ff} + STR_BITS'(idx_add);
   assign strips_sat = (strips_sum > STR_BITS'(SIZE_LIMIT)) ? SIZE_LIMIT :
                       strips_sum[SIZE_BITS-1:0];

   assign new_max = (ext_ff > max_ff) ? ext_ff : max_ff;

   always_comb begin
      len_in       = len_ff;
      rem_in       = rem_ff;
      ext_in       = ext_ff;
      mcand_in     = mcand_ff;
      ushift_in    = ushift_ff;
      acc_in       = acc_ff;
      max_in       = max_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         len_in = req_data.stored_length;
         rem_in = '0;
         ext_in = master_ok ? req_data.stored_length : '0;
      end
      if (cmd.div_step) begin
         len_in = {len_ff[SIZE_BITS-2:0], ge};
         rem_in = ge ? r_sub[UNIT_BITS-1:0] : r_sh[UNIT_BITS-1:0];
      end
      if (cmd.mulf) begin
         acc_in = ACC_BITS'(prefix_eff) + ACC_BITS'(rem_zero ? '0 : rem_ff);
      end
      if (cmd.strips) begin
         mcand_in  = MC_BITS'(strips_sat);
         ushift_in = unit_eff;
      end
      if (cmd.mul_step) begin
         if (ushift_ff[0]) acc_in = acc_ff + {1'b0, mcand_ff};
         mcand_in  = {mcand_ff[MC_BITS-2:0], 1'b0};
         ushift_in = {1'b0, ushift_ff[UNIT_BITS-1:1]};
      end
      if (cmd.clamp) begin
         ext_in = (acc_ff > ACC_BITS'(SIZE_LIMIT)) ? SIZE_LIMIT : acc_ff[SIZE_BITS-1:0];
      end
      if (cmd.update) begin
         if (last_ff) begin
            rsp_in.rebuilt_size = new_max;
            rsp_in.size_grew    = (new_max > cur_ff);
            rsp_valid_in        = 1'b1;
            max_in              = '0;
         end else begin
            max_in = new_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff    <= len_in;
      rem_ff    <= rem_in;
      ext_ff    <= ext_in;
      mcand_ff  <= mcand_in;
      ushift_ff <= ushift_in;
      acc_ff    <= acc_in;
      rsp_ff    <= rsp_in;
      if (cmd.load) begin
         idx_ff   <= req_data.subfile_index;
         cur_ff   <= req_data.current_size;
         last_ff  <= req_data.last_item;
         strip_ff <= strip_ok;
      end
      if (cmd.mulf) begin
         qf_ff <= QF_BITS'(q_adj) * QF_BITS'(factor_eff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.strip_path = strip_ff;
   assign sts.last       = last_ff;
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");

   a_last_clears_max: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_ff) |=> (max_ff == '0) && rsp_valid_ff)
      else $error("final request did not clear the maximum and post a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.update && last_ff) |-> !(rsp_valid_ff && !rsp_ready))
      else $error("response register overwritten while still pending");
`endif

endmodule

/* rtl/striped_file_size_rebuild.sv */
// Rebuilds the logical size of a round-robin striped file from one subfile length per
// request, keeping a running maximum and posting the size with a grew flag on the
// request marked last. One request is in work at a time. A master-strip, skipped or
// empty-subfile request goes from acceptance to the maximum update; a striped
// subfile runs a serial divider pass by the strip unit (one quotient bit a cycle), a
// factor multiply and strip-count step, a shift-add multiply by the strip unit, a
// clamp, the maximum update and the idle state that takes the next request. The
// response sits in an output register, so the next request is taken while it waits;
// a last request that finds the register still occupied waits in its update step.
// Config must be written only while the block is idle; it is not enforced here.
module striped_file_size_rebuild
   import sfsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_type                  rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   sfsr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   sfsr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sfsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

/* test/striped_file_size_rebuild_tb.sv */
`timescale 1ns / 100ps

module striped_file_size_rebuild_tb;
   import sfsr_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_SINGLE   = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_STRIPED  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_HYBRID   = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_RESERVED = 2'd3;

   localparam logic [SIZE_BITS-1:0] SIZE_LIMIT = '1;
   localparam int SETTLE_CYCLES  = 120;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_REQUESTS = 82;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   req_type pending_requests[$];
   rsp_type expected_sizes[$];
   rsp_type wanted_size;

   cfg_type              layout_shadow;
   logic [SIZE_BITS-1:0] largest_extent;
   int unsigned          requests_queued;
   int unsigned          requests_taken;
   int unsigned          send_gap;
   int unsigned          sink_stall;
   int unsigned          quiet_cycles;
   int unsigned          mismatches;
   bit                   idling_on;

   striped_file_size_rebuild dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int unsigned gap_length();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(10, 80);
   endfunction

   function automatic logic [63:0] effective_unit();
      return (layout_shadow.strip_unit_bytes == 0) ? 64'd1
                                                   : 64'(layout_shadow.strip_unit_bytes);
   endfunction

   function automatic int unsigned effective_factor();
      return (layout_shadow.stripe_factor > MAX_SUBFILES) ? MAX_SUBFILES
                                                          : layout_shadow.stripe_factor;
   endfunction

   // Highest byte covered by this request, folded into the running size;
   // a last request closes the file and yields the expected response.
   task automatic track_file_size(input req_type r);
      logic [127:0] len, unit, fac, idx, prefix, extent;
      logic         striped, hybrid, counts;
      rsp_type      closed;
      striped = layout_shadow.layout_mode != MODE_SINGLE;
      hybrid  = layout_shadow.layout_mode[1];
      unit    = 128'(effective_unit());
      fac     = 128'(effective_factor());
      prefix  = hybrid ? 128'(layout_shadow.hybrid_prefix_bytes) : 128'd0;
      len     = 128'(r.stored_length);
      idx     = 128'(r.subfile_index);
      extent  = '0;
      counts  = 1'b0;
      if (idx == 0) begin
         counts = !striped || hybrid;
         extent = len;
      end else if (striped && idx <= fac) begin
         counts = 1'b1;
         // exact arithmetic clamped once gives the same as saturating each step
         if (len == 0)
            extent = '0;
         else if (len % unit == 0)
            extent = prefix + (((len - 1) / unit) * fac + idx) * unit;
         else
            extent = prefix + ((len / unit) * fac + idx - 1) * unit + len % unit;
         if (extent > 128'(SIZE_LIMIT)) extent = 128'(SIZE_LIMIT);
      end
      if (counts && extent > 128'(largest_extent)) largest_extent = extent[SIZE_BITS-1:0];
      if (r.last_item) begin
         closed.rebuilt_size = largest_extent;
         closed.size_grew    = largest_extent > r.current_size;
         expected_sizes.push_back(closed);
         largest_extent = '0;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            track_file_size(req_data);
            requests_taken++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
               if (idling_on && $urandom_range(0, 2) == 0) send_gap <= gap_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         sink_stall <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_sizes.size() == 0) begin
               $error("unexpected response: rebuilt_size %0d size_grew %0b",
                      rsp_data.rebuilt_size, rsp_data.size_grew);
               mismatches++;
            end else begin
               wanted_size = expected_sizes.pop_front();
               if (rsp_data.rebuilt_size !== wanted_size.rebuilt_size) begin
                  $error("rebuilt_size: expected %0d, actual %0d",
                         wanted_size.rebuilt_size, rsp_data.rebuilt_size);
                  mismatches++;
               end
               if (rsp_data.size_grew !== wanted_size.size_grew) begin
                  $error("size_grew: expected %0b, actual %0b",
                         wanted_size.size_grew, rsp_data.size_grew);
                  mismatches++;
               end
            end
         end
         if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            rsp_ready  <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            sink_stall <= gap_length();
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("striped_file_size_rebuild regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_reg(input logic [1:0] reg_sel, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (reg_sel)
         REG_LAYOUT_MODE: layout_shadow.layout_mode         = value[MODE_BITS-1:0];
         REG_STRIP_UNIT:  layout_shadow.strip_unit_bytes    = value[UNIT_BITS-1:0];
         REG_FACTOR:      layout_shadow.stripe_factor       = value[FACTOR_BITS-1:0];
         REG_PREFIX:      layout_shadow.hybrid_prefix_bytes = value[PREFIX_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic set_layout(input logic [1:0] mode, input logic [31:0] unit,
                             input logic [31:0] factor, input logic [31:0] prefix);
      write_reg(REG_LAYOUT_MODE, 32'(mode));
      write_reg(REG_STRIP_UNIT, unit);
      write_reg(REG_FACTOR, factor);
      write_reg(REG_PREFIX, prefix);
   endtask

   task automatic add_request(input int unsigned idx, input logic [SIZE_BITS-1:0] len,
                              input logic [SIZE_BITS-1:0] cur, input bit last);
      req_type r;
      r.subfile_index = INDEX_BITS'(idx);
      r.stored_length = len;
      r.current_size  = cur;
      r.last_item     = last;
      pending_requests.push_back(r);
      requests_queued++;
   endtask

   // every request taken and every response back, then room for a non-last
   // striped request still grinding through the divider
   task automatic wait_drained();
      @(negedge clock);
      while (requests_taken != requests_queued || expected_sizes.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [SIZE_BITS-1:0] pick_length();
      logic [63:0] unit, len;
      unit = effective_unit();
      case ($urandom_range(0, 9))
         0:       len = 0;
         1:       len = 64'(SIZE_LIMIT);
         2:       len = {$urandom, $urandom};
         3, 4:    len = unit * $urandom_range(1, 8);
         5, 6:    len = unit * $urandom_range(0, 8) + $urandom_range(0, 32'(unit - 1));
         default: len = $urandom_range(1, 4096);
      endcase
      return len[SIZE_BITS-1:0];
   endfunction

   function automatic logic [SIZE_BITS-1:0] pick_current();
      logic [63:0] cur;
      case ($urandom_range(0, 4))
         0:       cur = 0;
         1:       cur = 64'(SIZE_LIMIT);
         2:       cur = {$urandom, $urandom};
         default: cur = $urandom_range(0, 1 << 22);
      endcase
      return cur[SIZE_BITS-1:0];
   endfunction

   task automatic write_random_layout();
      logic [31:0] mode, unit, factor, prefix;
      case ($urandom_range(0, 6))
         0, 1:    mode = 32'(MODE_STRIPED);
         2, 3:    mode = 32'(MODE_HYBRID);
         4:       mode = 32'(MODE_RESERVED);
         default: mode = 32'(MODE_SINGLE);
      endcase
      case ($urandom_range(0, 7))
         0:       unit = 0;
         1:       unit = 1;
         2:       unit = (1 << UNIT_BITS) - 1;
         3:       unit = 1 << 24;
         4:       unit = 65536;
         5, 6:    unit = $urandom_range(1, 64);
         default: unit = $urandom_range(1, (1 << UNIT_BITS) - 1);
      endcase
      case ($urandom_range(0, 7))
         0:       factor = 0;
         1:       factor = 31;
         2:       factor = MAX_SUBFILES;
         3:       factor = $urandom_range(MAX_SUBFILES + 1, 31);
         default: factor = $urandom_range(1, MAX_SUBFILES);
      endcase
      case ($urandom_range(0, 3))
         0:       prefix = 0;
         1:       prefix = '1;
         2:       prefix = $urandom_range(0, 1 << 20);
         default: prefix = $urandom;
      endcase
      set_layout(mode[1:0], unit, factor, prefix);
   endtask

   // one file: mostly reports from the master and in-range subfiles, some noise
   task automatic queue_file();
      int unsigned reports, fac, idx;
      fac = effective_factor();
      reports = $urandom_range(1, fac + 2);
      for (int unsigned i = 0; i < reports; i++) begin
         if ($urandom_range(0, 9) < 8) idx = $urandom_range(0, fac);
         else idx = $urandom_range(0, MAX_SUBFILES);
         add_request(idx, pick_length(), pick_current(),
                     i == reports - 1 || $urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      layout_shadow   = '{MODE_RESET, UNIT_RESET, FACTOR_RESET, PREFIX_RESET};
      largest_extent  = '0;
      requests_queued = 0;
      requests_taken  = 0;
      mismatches      = 0;
      quiet_cycles    = 0;
      idling_on       = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // registers at their reset values: single file
      add_request(0, SIZE_LIMIT, 0, 1);
      add_request(MAX_SUBFILES, 1000, 0, 1);
      add_request(0, 0, 0, 0);
      add_request(0, 777, 777, 1);
      wait_drained();

      // striped: master ignored, top subfile saturates
      set_layout(MODE_STRIPED, 1, MAX_SUBFILES, '1);
      add_request(0, 12345, 0, 0);
      add_request(MAX_SUBFILES, SIZE_LIMIT, 0, 0);
      add_request(1, 1, SIZE_LIMIT, 1);
      wait_drained();

      // hybrid, widest unit, factor clipped to the subfile count
      set_layout(MODE_HYBRID, (1 << UNIT_BITS) - 1, 31, '1);
      add_request(MAX_SUBFILES, (1 << UNIT_BITS) - 1, 0, 0);
      add_request(3, 1 << UNIT_BITS, 0, 0);
      add_request(0, 7, 0, 0);
      add_request(1, 0, 0, 1);
      wait_drained();

      // mode three behaves as hybrid; zero factor, zero unit
      set_layout(MODE_RESERVED, 0, 0, 100);
      add_request(1, 50, 0, 0);
      add_request(0, 9, 8, 1);
      wait_drained();

      set_layout(MODE_STRIPED, 4096, 4, 0);
      add_request(5, 100000, 0, 0);
      add_request(2, 8192, 0, 0);
      add_request(3, 5000, 0, 0);
      add_request(4, 4096 * 3 - 1, 0, 0);
      add_request(1, 1, 20000, 1);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_random_layout();
         idling_on = ($urandom_range(0, 3) != 0);
         while (requests_queued < 18 + (p + 1) * PHASE_REQUESTS) queue_file();
         wait_drained();
      end

      if (mismatches == 0) begin
         $display("striped_file_size_rebuild regression: pass");
      end else begin
         $display("striped_file_size_rebuild regression: fail");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/sfsr_pkg.sv
rtl/sfsr_csr.sv
rtl/sfsr_ctrl.sv
rtl/sfsr_dp.sv
rtl/striped_file_size_rebuild.sv
test/striped_file_size_rebuild_tb.sv
